// File: rtl/sspc_pkg.sv
// shared types and constants for the servo status packet checker
package sspc_pkg;

    // packet status codes
    localparam logic [2:0] STATUS_OK     = 3'd0;
    localparam logic [2:0] STATUS_CKSUM  = 3'd1;
    localparam logic [2:0] STATUS_DEVERR = 3'd2;
    localparam logic [2:0] STATUS_SHORT  = 3'd3;
    localparam logic [2:0] STATUS_OVFL   = 3'd4;

    // byte positions inside a status packet
    localparam logic [7:0] IDX_SUM_START = 8'd2;
    localparam logic [7:0] IDX_ERROR     = 8'd4;
    localparam logic [7:0] IDX_PARAM     = 8'd5;
    localparam logic [7:0] IDX_MAX       = 8'd255;

    // device error byte: the low seven bits map one to one onto the flags
    localparam logic [7:0] ERR_FLAG_MASK = 8'h7F;

    typedef logic [2:0] status_t;
    typedef logic [6:0] flags_t;

    // bit positions in the output tdata word
    localparam int OUT_ADDR_LSB   = 0;
    localparam int OUT_VALUE_LSB  = 8;
    localparam int OUT_STATUS_LSB = 16;
    localparam int OUT_FLAGS_LSB  = 19;

endpackage

// File: rtl/sspc_ram.sv
// generic single write port, single read port ram with registered read data
module sspc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/servo_status_packet_checker.sv
// top level of the servo status packet checker
//
// Takes a status packet one byte per request (one per cycle while idle), sums
// bytes 2 to n-2, keeps the device error byte and stores the parameter bytes
// in a MAX_PARAMS deep parameter ram. The request carrying tlast is judged as
// it is taken: a short frame, device error or checksum failure gives one
// result; a clean packet gives one mirror write per stored parameter (or one
// result with no write when there are none). Each write is read from the
// parameter ram in S_READ and loaded in S_EMIT, and the input stays stalled
// from the last byte until the final result of that packet is loaded into
// the output register. Parameters beyond MAX_PARAMS are dropped and reported
// as overflow. Sticky error flags are carried on every result.
module servo_status_packet_checker
    import sspc_pkg::*;
#(
    parameter int MAX_PARAMS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] start_address
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] reg_address, [15:8] reg_value,
                                   // [18:16] packet_status, [25:19] error_flags
    output logic        m_tuser,   // [0] data_valid
    output logic        m_tlast    // last_result
);

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam logic [7:0] MAX_P8 = 8'(MAX_PARAMS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_JUDGE = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [7:0]    byte_index_reg, byte_index_next;
    logic [7:0]    running_sum_reg, running_sum_next;
    logic [7:0]    error_byte_reg, error_byte_next;
    logic [7:0]    base_address_reg, base_address_next;
    logic          overflow_seen_reg, overflow_seen_next;
    flags_t        sticky_reg, sticky_next;
    status_t       verdict_reg, verdict_next;
    logic [CW-1:0] nparams_reg, nparams_next;
    logic [CW-1:0] emit_idx_reg, emit_idx_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_addr_reg, out_addr_next;
    logic [7:0]    out_value_reg, out_value_next;
    logic          out_dv_reg, out_dv_next;
    status_t       out_status_reg, out_status_next;
    flags_t        out_flags_reg, out_flags_next;
    logic          out_last_reg, out_last_next;

    logic          in_req;
    logic [7:0]    rx_byte;
    logic          first_byte;
    logic [7:0]    idx_eff, sum_eff, err_eff;
    logic          ovf_eff;
    logic [7:0]    param_pos;
    logic [7:0]    np_full;
    logic          out_free;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    assign rx_byte    = s_tdata[7:0];
    assign first_byte = s_tuser;
    assign s_tready   = (state_reg == S_IDLE);
    assign in_req     = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;

    // packet state as seen by this byte, a first mark restarts it
    assign idx_eff   = first_byte ? 8'd0 : byte_index_reg;
    assign sum_eff   = first_byte ? 8'd0 : running_sum_reg;
    assign err_eff   = first_byte ? 8'd0 : error_byte_reg;
    assign ovf_eff   = first_byte ? 1'b0 : overflow_seen_reg;
    assign param_pos = idx_eff - IDX_PARAM;
    assign np_full   = idx_eff - IDX_PARAM;

    // parameter buffer write on non-last bytes
    assign ram_we    = in_req && !s_tlast && (idx_eff >= IDX_PARAM) && (param_pos < MAX_P8);
    assign ram_waddr = param_pos[AW-1:0];
    assign ram_re    = (state_reg == S_READ);

    sspc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PARAMS)
    ) u_param_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (emit_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // packet accumulation, judgement and emission sequencing
    always_comb
    begin
        state_next         = state_reg;
        byte_index_next    = byte_index_reg;
        running_sum_next   = running_sum_reg;
        error_byte_next    = error_byte_reg;
        base_address_next  = base_address_reg;
        overflow_seen_next = overflow_seen_reg;
        sticky_next        = sticky_reg;
        verdict_next       = verdict_reg;
        nparams_next       = nparams_reg;
        emit_idx_next      = emit_idx_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_addr_next   = out_addr_reg;
        out_value_next  = out_value_reg;
        out_dv_next     = out_dv_reg;
        out_status_next = out_status_reg;
        out_flags_next  = out_flags_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    running_sum_next   = sum_eff;
                    error_byte_next    = err_eff;
                    overflow_seen_next = ovf_eff;
                    if (first_byte)
                    begin
                        base_address_next = s_tdata[15:8];
                    end
                    if (!s_tlast)
                    begin
                        if (idx_eff >= IDX_SUM_START)
                        begin
                            running_sum_next = sum_eff + rx_byte;
                        end
                        if (idx_eff == IDX_ERROR)
                        begin
                            error_byte_next = rx_byte;
                        end
                        if ((idx_eff >= IDX_PARAM) && (param_pos >= MAX_P8))
                        begin
                            overflow_seen_next = 1'b1;
                        end
                        byte_index_next = (idx_eff == IDX_MAX) ? idx_eff : idx_eff + 8'd1;
                    end
                    else
                    begin
                        byte_index_next  = 8'd0;
                        running_sum_next = 8'd0;
                        nparams_next     = '0;
                        state_next       = S_JUDGE;
                        if (idx_eff < IDX_PARAM)
                        begin
                            verdict_next = STATUS_SHORT;
                        end
                        else if (err_eff != 8'd0)
                        begin
                            verdict_next = STATUS_DEVERR;
                            sticky_next  = flags_t'(err_eff & ERR_FLAG_MASK);
                        end
                        else if (~sum_eff != rx_byte)
                        begin
                            verdict_next = STATUS_CKSUM;
                        end
                        else
                        begin
                            sticky_next = '0;
                            if (np_full > MAX_P8)
                            begin
                                nparams_next       = CW'(MAX_PARAMS);
                                overflow_seen_next = 1'b1;
                                verdict_next       = STATUS_OVFL;
                            end
                            else
                            begin
                                nparams_next = np_full[CW-1:0];
                                verdict_next = ovf_eff ? STATUS_OVFL : STATUS_OK;
                            end
                        end
                    end
                end
            end
            S_JUDGE:
            begin
                if (nparams_reg != '0)
                begin
                    emit_idx_next = '0;
                    state_next    = S_READ;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = 8'd0;
                    out_value_next  = 8'd0;
                    out_dv_next     = 1'b0;
                    out_status_next = verdict_reg;
                    out_flags_next  = sticky_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = base_address_reg + 8'(emit_idx_reg);
                    out_value_next  = ram_rdata;
                    out_dv_next     = 1'b1;
                    out_status_next = verdict_reg;
                    out_flags_next  = sticky_reg;
                    out_last_next   = (emit_idx_reg + CW'(1) == nparams_reg);
                    emit_idx_next   = emit_idx_reg + CW'(1);
                    state_next      = (emit_idx_reg + CW'(1) == nparams_reg) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            byte_index_reg    <= 8'd0;
            running_sum_reg   <= 8'd0;
            error_byte_reg    <= 8'd0;
            base_address_reg  <= 8'd0;
            overflow_seen_reg <= 1'b0;
            sticky_reg        <= '0;
            nparams_reg       <= '0;
            emit_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            byte_index_reg    <= byte_index_next;
            running_sum_reg   <= running_sum_next;
            error_byte_reg    <= error_byte_next;
            base_address_reg  <= base_address_next;
            overflow_seen_reg <= overflow_seen_next;
            sticky_reg        <= sticky_next;
            nparams_reg       <= nparams_next;
            emit_idx_reg      <= emit_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        verdict_reg    <= verdict_next;
        out_addr_reg   <= out_addr_next;
        out_value_reg  <= out_value_next;
        out_dv_reg     <= out_dv_next;
        out_status_reg <= out_status_next;
        out_flags_reg  <= out_flags_next;
        out_last_reg   <= out_last_next;
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_dv_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_flags_reg, out_status_reg, out_value_reg, out_addr_reg};

endmodule

// File: rtl/sspc_checker.sv
// port level assertions for the servo status packet checker, with bind
module sspc_checker
    import sspc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic [2:0] status;
    assign status = m_tdata[OUT_STATUS_LSB +: 3];

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a result without a mirror write is always the only one of its packet
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("non-write result without last mark");

    // mirror writes come only from clean or overflowed packets
    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (status == STATUS_OK || status == STATUS_OVFL))
        else $error("mirror write on a rejected packet");

    // rejected packets carry zero address and value
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == STATUS_CKSUM || status == STATUS_DEVERR ||
                     status == STATUS_SHORT) |-> (m_tdata[15:0] == 16'd0) && !m_tuser)
        else $error("rejected packet carries write payload");

endmodule

bind servo_status_packet_checker sspc_checker u_sspc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
